>>> rtl/dipas_pkg.sv
// ----------------------------------------------------------------------------
// Dual-input peak and auto-select shared definitions
// Types, register indexes, routing modes and selection codes used by the
// lanes, the merge stage and the top level.
// ----------------------------------------------------------------------------
package dipas_pkg;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROUTING_MODE     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CHANNELS_PRESENT = 2'd1;

  localparam logic [2:0] MODE_INPUT1        = 3'd0;
  localparam logic [2:0] MODE_INPUT2        = 3'd1;
  localparam logic [2:0] MODE_AUTO_MONO     = 3'd2;
  localparam logic [2:0] MODE_TEST_SIGNAL   = 3'd3;
  localparam logic [2:0] MODE_FIRST_PRESENT = 3'd4;

  localparam logic [1:0] PRESENT_BOTH = 2'b11;

  typedef logic signed [1:0] choice_t;

  localparam choice_t CHOICE_FIRST  = 2'sb00;
  localparam choice_t CHOICE_SECOND = 2'sb01;
  localparam choice_t CHOICE_NONE   = 2'sb11;
  localparam choice_t CHOICE_BAD    = 2'sb10;

  // Single-precision 0.999 scaled to 2^24.
  localparam logic [63:0] CLIP_NUM = 64'd16760439;
  localparam logic [63:0] DET_DIV  = 64'd10000;

  typedef struct packed {
    logic [2:0] routing_mode;
    logic [1:0] channels_present;
  } cfg_t;

  typedef struct packed {
    logic acc;
    logic close;
  } frame_ctl_t;

endpackage

>>> rtl/dipas_lane.sv
// ----------------------------------------------------------------------------
// Dual-input peak lane
// Per-channel magnitude, running peak, block peak capture and clip detection.
// ----------------------------------------------------------------------------
module dipas_lane
  import dipas_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  frame_ctl_t             frm,
  input  logic                   present,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] blk_peak,
  output logic                   clip_hit
);

  localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [63:0] CLIP_PROD  = CLIP_NUM * FULL_SCALE;
  localparam logic [63:0] CLIP_LEVEL = (CLIP_PROD + 64'd16777215) >> 24;

  logic [SAMPLE_BITS-1:0] mag;
  logic [SAMPLE_BITS-1:0] run_peak_r;
  logic [SAMPLE_BITS-1:0] run_peak_nxt;
  logic [SAMPLE_BITS-1:0] peak_upd;
  logic [SAMPLE_BITS-1:0] blk_peak_r;

  assign mag      = sample[SAMPLE_BITS-1]
                  ? (~sample + {{(SAMPLE_BITS - 1){1'b0}}, 1'b1}) : sample;
  assign peak_upd = (present && (mag > run_peak_r)) ? mag : run_peak_r;
  assign clip_hit = present && (mag >= CLIP_LEVEL[SAMPLE_BITS-1:0]);

  always_comb begin
    run_peak_nxt = run_peak_r;
    if (frm.acc) begin
      run_peak_nxt = frm.close ? '0 : peak_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_peak_r <= '0;
    end else begin
      run_peak_r <= run_peak_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frm.acc && frm.close) begin
      blk_peak_r <= peak_upd;
    end
  end

  assign blk_peak = blk_peak_r;

endmodule

>>> rtl/dipas_merge.sv
// ----------------------------------------------------------------------------
// Dual-input peak merge stage
// Clip counting, block capture, channel selection and the result register.
// ----------------------------------------------------------------------------
module dipas_merge
  import dipas_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int CLIP_COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfg_t                       cfg,
  input  frame_ctl_t                 frm,
  input  logic                       hit_first,
  input  logic                       hit_second,
  input  logic [SAMPLE_BITS-1:0]     blk_peak_first,
  input  logic [SAMPLE_BITS-1:0]     blk_peak_second,
  output logic                       in_stall,
  output logic                       out_valid,
  input  logic                       out_stall,
  output choice_t                    out_chosen_input,
  output logic [SAMPLE_BITS-1:0]     out_peak_first,
  output logic [SAMPLE_BITS-1:0]     out_peak_second,
  output logic [CLIP_COUNT_BITS-1:0] out_clip_total
);

  localparam logic [63:0] FULL_SCALE = 64'd1 << (SAMPLE_BITS - 1);
  localparam logic [63:0] DET_LEVEL  = FULL_SCALE / DET_DIV;
  localparam logic [CLIP_COUNT_BITS-1:0] CLIP_MAX = '1;

  logic [CLIP_COUNT_BITS-1:0] cnt_r, cnt_nxt, cnt_sat;
  logic [CLIP_COUNT_BITS:0]   cnt_sum;
  logic [CLIP_COUNT_BITS-1:0] blk_clip_r;
  logic                       s1_vld_r, s1_vld_nxt;
  logic                       out_free, s1_move;
  choice_t                    rem_r, rem_nxt;
  choice_t                    sel;
  choice_t                    first_pres, rem_cur, louder;
  logic                       p0, p1;
  logic [SAMPLE_BITS-1:0]     sp, cp;
  logic [SAMPLE_BITS+2:0]     sp5, cp8;
  logic                       out_valid_r, out_valid_nxt;
  choice_t                    out_chosen_r;
  logic [SAMPLE_BITS-1:0]     out_peak_first_r, out_peak_second_r;
  logic [CLIP_COUNT_BITS-1:0] out_clip_r;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_vld_r && out_free;
  assign in_stall = s1_vld_r && !out_free;

  assign cnt_sum = {1'b0, cnt_r} + {{CLIP_COUNT_BITS{1'b0}}, hit_first}
                 + {{CLIP_COUNT_BITS{1'b0}}, hit_second};
  assign cnt_sat = (cnt_sum > {1'b0, CLIP_MAX}) ? CLIP_MAX : cnt_sum[CLIP_COUNT_BITS-1:0];

  always_comb begin
    cnt_nxt = cnt_r;
    if (frm.acc) begin
      cnt_nxt = frm.close ? '0 : cnt_sat;
    end
  end

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (frm.acc && frm.close) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_move) begin
      s1_vld_nxt = 1'b0;
    end
  end

  assign p0         = cfg.channels_present[0];
  assign p1         = cfg.channels_present[1];
  assign first_pres = p0 ? CHOICE_FIRST : (p1 ? CHOICE_SECOND : CHOICE_NONE);
  assign rem_cur    = ((rem_r == CHOICE_FIRST && p0) || (rem_r == CHOICE_SECOND && p1))
                    ? rem_r : first_pres;
  assign louder     = (blk_peak_second > blk_peak_first) ? CHOICE_SECOND : CHOICE_FIRST;
  assign sp         = (louder == CHOICE_SECOND) ? blk_peak_second : blk_peak_first;
  assign cp         = (rem_cur == CHOICE_SECOND) ? blk_peak_second : blk_peak_first;
  assign sp5        = {1'b0, sp, 2'b00} + {3'b000, sp};
  assign cp8        = {cp, 3'b000};

  always_comb begin
    rem_nxt = rem_cur;
    if (cfg.channels_present == PRESENT_BOTH && louder != rem_cur
        && {{(64 - SAMPLE_BITS){1'b0}}, sp} > DET_LEVEL && sp5 > cp8) begin
      rem_nxt = louder;
    end
  end

  always_comb begin
    case (cfg.routing_mode)
      MODE_INPUT1:      sel = p0 ? CHOICE_FIRST : CHOICE_NONE;
      MODE_INPUT2:      sel = p1 ? CHOICE_SECOND : CHOICE_NONE;
      MODE_AUTO_MONO:   sel = rem_nxt;
      MODE_TEST_SIGNAL: sel = CHOICE_NONE;
      default:          sel = first_pres;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= CHOICE_NONE;
    end else begin
      cnt_r       <= cnt_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move && cfg.routing_mode == MODE_AUTO_MONO) begin
        rem_r <= rem_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frm.acc && frm.close) begin
      blk_clip_r <= cnt_sat;
    end
    if (s1_move) begin
      out_chosen_r      <= sel;
      out_peak_first_r  <= blk_peak_first;
      out_peak_second_r <= blk_peak_second;
      out_clip_r        <= blk_clip_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_chosen_input = out_chosen_r;
  assign out_peak_first   = out_peak_first_r;
  assign out_peak_second  = out_peak_second_r;
  assign out_clip_total   = out_clip_r;

`ifndef SYNTHESIS
  a_held_block: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_move |=> s1_vld_r)
    else $error("Captured block transaction was dropped while the output was stalled.");

  a_close_capture: assert property (@(posedge clk) disable iff (!rst_n)
    frm.acc && frm.close |=> s1_vld_r)
    else $error("Block end transaction was not captured.");

  a_clip_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CLIP_MAX && frm.acc && !frm.close |=> cnt_r == CLIP_MAX)
    else $error("Clip counter wrapped instead of saturating.");

  a_rem_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_move && cfg.routing_mode == MODE_AUTO_MONO) |=> $stable(rem_r))
    else $error("Remembered choice changed outside an auto mono result.");

  a_choice_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_chosen_r != CHOICE_BAD)
    else $error("Selection output carries an invalid code.");
`endif

endmodule

>>> rtl/dual_input_peak_auto_select_core.sv
// ----------------------------------------------------------------------------
// Dual-input peak and auto-select core
// Tracks per-block peaks and clip counts of two channels and selects an input.
//
//   Channel  Direction  Handshake           Payload
//   in_      sink       in_valid/in_stall   sample_first, sample_second, block_end
//   out_     source     out_valid/out_stall chosen_input, peak_first, peak_second,
//                                           clip_total
//   cfg_     sink       cfg_valid/cfg_ready index, data
//
// Unless stalled, one frame is taken every cycle; two lanes update peaks in the cycle of acceptance.
// After its end frame is accepted, a block result passes the block end stage, then the output register.
// The block end stage and the output register form a two-entry buffer, so input
// stalls only while a captured block result waits behind a stalled output.
// Reset is synchronous and clears the running peaks, the clip count and the remembered choice.
// ----------------------------------------------------------------------------
module dual_input_peak_auto_select_core
  import dipas_pkg::*;
#(
  parameter int SAMPLE_BITS     = 24,
  parameter int CLIP_COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [SAMPLE_BITS-1:0]     in_sample_first,
  input  logic [SAMPLE_BITS-1:0]     in_sample_second,
  input  logic                       in_block_end,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_chosen_input,
  output logic [SAMPLE_BITS-1:0]     out_peak_first,
  output logic [SAMPLE_BITS-1:0]     out_peak_second,
  output logic [CLIP_COUNT_BITS-1:0] out_clip_total,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  cfg_t                   cfg_r, cfg_nxt;
  frame_ctl_t             frm;
  logic                   hit_first, hit_second;
  logic [SAMPLE_BITS-1:0] blk_peak_first, blk_peak_second;
  choice_t                chosen;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROUTING_MODE:     cfg_nxt.routing_mode     = cfg_data;
        REG_CHANNELS_PRESENT: cfg_nxt.channels_present = cfg_data[1:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.routing_mode     <= MODE_FIRST_PRESENT;
      cfg_r.channels_present <= PRESENT_BOTH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign frm.acc   = in_valid && !in_stall;
  assign frm.close = in_block_end;

  dipas_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm      (frm),
    .present  (cfg_r.channels_present[0]),
    .sample   (in_sample_first),
    .blk_peak (blk_peak_first),
    .clip_hit (hit_first)
  );

  dipas_lane #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_lane_second (
    .clk      (clk),
    .rst_n    (rst_n),
    .frm      (frm),
    .present  (cfg_r.channels_present[1]),
    .sample   (in_sample_second),
    .blk_peak (blk_peak_second),
    .clip_hit (hit_second)
  );

  dipas_merge #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .CLIP_COUNT_BITS(CLIP_COUNT_BITS)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .frm              (frm),
    .hit_first        (hit_first),
    .hit_second       (hit_second),
    .blk_peak_first   (blk_peak_first),
    .blk_peak_second  (blk_peak_second),
    .in_stall         (in_stall),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_chosen_input (chosen),
    .out_peak_first   (out_peak_first),
    .out_peak_second  (out_peak_second),
    .out_clip_total   (out_clip_total)
  );

  assign out_chosen_input = chosen;

endmodule
